>>> rtl/core/ifm_pkg.sv
// ----------------------------------------------------------------------------
// ifm_pkg
// Shared codes and types of the integer field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ifm_pkg;

	// conversion codes
	localparam logic [2:0] ACT_D   = 3'd0;
	localparam logic [2:0] ACT_U   = 3'd1;
	localparam logic [2:0] ACT_O   = 3'd2;
	localparam logic [2:0] ACT_X   = 3'd3;
	localparam logic [2:0] ACT_XU  = 3'd4;
	localparam logic [2:0] ACT_C   = 3'd5;
	localparam logic [2:0] ACT_PCT = 3'd6;
	localparam logic [2:0] ACT_NONE = 3'd7;

	// length modifier codes
	localparam logic [1:0] LEN_H = 2'd1;
	localparam logic [1:0] LEN_L = 2'd2;

	// radix select of the digit unit
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam int NUM_DIGITS = 24;

	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	// field layout handed to the emitter
	typedef struct packed {
		logic [7:0] padl;
		logic [1:0] plen;
		logic [7:0] zeros;
		logic [4:0] ndig;
		logic [7:0] padr;
		logic [7:0] total;
		logic [7:0] pre0;
		logic [7:0] pre1;
		logic       single;
		logic [7:0] single_char;
		logic       upper;
	} lay_t;

endpackage

`default_nettype wire

>>> rtl/core/integer_field_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_field_formatter_top
// Formats one printf integer or character conversion into ASCII characters.
// ----------------------------------------------------------------------------
// A conversion is taken when start is high and busy low; busy then stays
// high until the last character beat. Characters come out one per cycle on
// out_char, save where the emitter switches field segments, char_strobe
// high for one cycle each, last_char on the final one; the receiver cannot
// stall them. Per conversion: the digit unit splits the argument into
// digits, for decimal by a shift-add-3 loop over the 16, 32 or 64 argument
// bits (c and percent skip it); the layout steps S_LAY1 and S_LAY2 follow;
// the emitter then walks the segments and gives the final beat, after which
// busy drops. A conversion that yields no characters (action code 7, or an
// empty field) produces no beat; busy ends with S_LAY2, or never rises for 7.
`default_nettype none

module integer_field_formatter_top #(
	parameter int MAX_FIELD = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  action,
	input  wire logic [63:0] arg_value,
	input  wire logic [1:0]  length_mod,
	input  wire logic        flag_left,
	input  wire logic        flag_plus,
	input  wire logic        flag_space,
	input  wire logic        flag_zero,
	input  wire logic        flag_alt,
	input  wire logic [6:0]  field_width,
	input  wire logic [5:0]  digit_precision,
	input  wire logic        precision_given,
	output logic [7:0]       out_char,
	output logic             last_char,
	output logic             char_strobe
);

	localparam logic [7:0] MAX_W = 8'(MAX_FIELD);
	localparam logic [7:0] MAX_P = 8'(MAX_FIELD - 2);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_LAY1 = 3'd2;
	localparam logic [2:0] S_LAY2 = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]  state_q;
	logic        go_q;
	logic        emit_go_q;
	logic [2:0]  act_q;
	logic [63:0] mag_q;
	logic [1:0]  len_q;
	logic        neg_q, nz_q, left_q, plus_q, space_q, zero_q, alt_q, pg_q;
	logic [7:0]  w_q;
	logic [7:0]  p_q;
	logic [7:0]  char_q;
	logic [7:0]  z0_q;
	logic [1:0]  plen_q;
	logic [4:0]  nd_q;
	logic [7:0]  body_q;
	ifm_pkg::lay_t lay_q;

	logic [63:0] mask_d, masked_d, mag_d;
	logic        neg_d, accept;
	logic [1:0]  base_d;
	ifm_pkg::digits_t digits;
	logic [4:0]  ndig;
	logic        dig_done;
	logic        is_int, is_single;
	logic [4:0]  nde;
	logic [7:0]  prec, z0, pad, zf, padf, total;
	logic [1:0]  plen;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// argument truncation and sign
	always_comb begin
		if (length_mod == ifm_pkg::LEN_H)      mask_d = 64'h0000_0000_0000_FFFF;
		else if (length_mod == ifm_pkg::LEN_L) mask_d = '1;
		else                                   mask_d = 64'h0000_0000_FFFF_FFFF;
		masked_d = arg_value & mask_d;
		neg_d    = (action == ifm_pkg::ACT_D) && ((masked_d & ((mask_d >> 1) + 64'd1)) != 64'd0);
		mag_d    = neg_d ? ((~masked_d + 64'd1) & mask_d) : masked_d;
	end

	always_comb begin
		if (act_q == ifm_pkg::ACT_O)                                   base_d = ifm_pkg::BASE_OCT;
		else if (act_q == ifm_pkg::ACT_X || act_q == ifm_pkg::ACT_XU) base_d = ifm_pkg::BASE_HEX;
		else                                                           base_d = ifm_pkg::BASE_DEC;
	end

	ifm_digit_unit u_digits (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go_q),
		.mag        (mag_q),
		.base       (base_d),
		.length_mod (len_q),
		.digits     (digits),
		.ndig       (ndig),
		.done       (dig_done)
	);

	// first layout step: digit count, precision zeros, prefix length
	always_comb begin
		is_single = (act_q == ifm_pkg::ACT_C) || (act_q == ifm_pkg::ACT_PCT);
		nde  = is_single ? 5'd1 : ndig;
		prec = is_single ? 8'd0 : (pg_q ? p_q : 8'd1);
		z0   = (prec > {3'd0, nde}) ? prec - {3'd0, nde} : 8'd0;
		if (act_q == ifm_pkg::ACT_O && alt_q && z0 == 8'd0) z0 = 8'd1;
		plen = 2'd0;
		if (act_q == ifm_pkg::ACT_D) begin
			if (neg_q || plus_q || space_q) plen = 2'd1;
		end else if ((act_q == ifm_pkg::ACT_X || act_q == ifm_pkg::ACT_XU) && alt_q && nz_q) begin
			plen = 2'd2;
		end
	end

	// second layout step: padding, zero fold, capped total
	always_comb begin
		is_int = !is_single;
		pad  = (w_q > body_q) ? w_q - body_q : 8'd0;
		zf   = z0_q;
		padf = pad;
		if (is_int && !left_q && zero_q && !pg_q) begin
			zf   = z0_q + pad;
			padf = 8'd0;
		end
		// folded zeros still count toward the field length
		total = body_q + pad;
		if (total > MAX_W) total = MAX_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			go_q      <= 1'b0;
			emit_go_q <= 1'b0;
		end else begin
			go_q      <= 1'b0;
			emit_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ifm_pkg::ACT_C || action == ifm_pkg::ACT_PCT) begin
							state_q <= S_LAY1;
						end else if (action != ifm_pkg::ACT_NONE) begin
							state_q <= S_CONV;
							go_q    <= 1'b1;
						end
					end
				end
				S_CONV: if (dig_done) state_q <= S_LAY1;
				S_LAY1: state_q <= S_LAY2;
				S_LAY2: begin
					if (total == 8'd0) begin
						state_q <= S_IDLE;
					end else begin
						state_q   <= S_EMIT;
						emit_go_q <= 1'b1;
					end
				end
				S_EMIT: if (char_strobe && last_char) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// beat capture and layout registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			mag_q   <= mag_d;
			len_q   <= length_mod;
			neg_q   <= neg_d;
			nz_q    <= (masked_d != 64'd0);
			left_q  <= flag_left;
			plus_q  <= flag_plus;
			space_q <= flag_space;
			zero_q  <= flag_zero;
			alt_q   <= flag_alt;
			pg_q    <= precision_given;
			char_q  <= (action == ifm_pkg::ACT_PCT) ? 8'd37 : arg_value[7:0];
			if (action == ifm_pkg::ACT_PCT)  w_q <= 8'd0;
			else if ({1'b0, field_width} > MAX_W) w_q <= MAX_W;
			else                                  w_q <= {1'b0, field_width};
			p_q <= ({2'd0, digit_precision} > MAX_P) ? MAX_P : {2'd0, digit_precision};
		end
		if (state_q == S_LAY1) begin
			z0_q   <= z0;
			plen_q <= plen;
			nd_q   <= nde;
			body_q <= {6'd0, plen} + z0 + {3'd0, nde};
		end
		if (state_q == S_LAY2) begin
			lay_q.padl        <= left_q ? 8'd0 : padf;
			lay_q.padr        <= left_q ? padf : 8'd0;
			lay_q.plen        <= plen_q;
			lay_q.zeros       <= zf;
			lay_q.ndig        <= nd_q;
			lay_q.total       <= total;
			lay_q.pre0        <= (act_q == ifm_pkg::ACT_D) ?
			                     (neg_q ? "-" : (plus_q ? "+" : " ")) : "0";
			lay_q.pre1        <= (act_q == ifm_pkg::ACT_XU) ? "X" : "x";
			lay_q.single      <= is_single;
			lay_q.single_char <= char_q;
			lay_q.upper       <= (act_q == ifm_pkg::ACT_XU);
		end
	end

	ifm_emitter u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (emit_go_q),
		.lay         (lay_q),
		.digits      (digits),
		.out_char    (out_char),
		.last_char   (last_char),
		.char_strobe (char_strobe)
	);

endmodule

`default_nettype wire

>>> rtl/core/ifm_digit_unit.sv
// ----------------------------------------------------------------------------
// ifm_digit_unit
// Splits a magnitude into digits: octal and hex by slicing, decimal by
// shift-add-3 one bit per cycle. Reports the significant digit count.
// ----------------------------------------------------------------------------
`default_nettype none

module ifm_digit_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [63:0]      mag,
	input  wire logic [1:0]       base,
	input  wire logic [1:0]       length_mod,
	output ifm_pkg::digits_t      digits,
	output logic [4:0]            ndig,
	output logic                  done
);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_DAB  = 2'd1;
	localparam logic [1:0] U_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [6:0]       iter_q;
	logic [63:0]      sh_q;
	ifm_pkg::digits_t dig_q;
	logic [4:0]       ndig_q;
	logic             done_q;

	ifm_pkg::digits_t slice_d;
	ifm_pkg::digits_t adj_d;
	logic [4*ifm_pkg::NUM_DIGITS-1:0] adj_flat;
	logic [65:0]      oct_ext;
	logic [4:0]       nd_d;

	// direct radix slicing
	always_comb begin
		oct_ext = {2'b00, mag};
		for (int i = 0; i < ifm_pkg::NUM_DIGITS; i++) begin
			slice_d[i] = 4'd0;
			if (base == ifm_pkg::BASE_HEX) begin
				if (i < 16) slice_d[i] = mag[4*i +: 4];
			end else begin
				if (i < 22) slice_d[i] = {1'b0, oct_ext[3*i +: 3]};
			end
		end
	end

	// add 3 to every BCD digit of five or more
	always_comb begin
		for (int i = 0; i < ifm_pkg::NUM_DIGITS; i++) begin
			adj_d[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
		adj_flat = adj_d;
	end

	// highest nonzero digit
	always_comb begin
		nd_d = 5'd0;
		for (int i = 0; i < ifm_pkg::NUM_DIGITS; i++) begin
			if (dig_q[i] != 4'd0) nd_d = 5'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (go) state_q <= (base == ifm_pkg::BASE_DEC) ? U_DAB : U_FIN;
				end
				U_DAB: begin
					if (iter_q == 7'd1) state_q <= U_FIN;
				end
				U_FIN: begin
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (go) begin
					if (base == ifm_pkg::BASE_DEC) begin
						dig_q <= '0;
						if (length_mod == ifm_pkg::LEN_H) begin
							sh_q   <= mag << 48;
							iter_q <= 7'd16;
						end else if (length_mod == ifm_pkg::LEN_L) begin
							sh_q   <= mag;
							iter_q <= 7'd64;
						end else begin
							sh_q   <= mag << 32;
							iter_q <= 7'd32;
						end
					end else begin
						dig_q <= slice_d;
					end
				end
			end
			U_DAB: begin
				dig_q  <= {adj_flat[4*ifm_pkg::NUM_DIGITS-2:0], sh_q[63]};
				sh_q   <= sh_q << 1;
				iter_q <= iter_q - 7'd1;
			end
			U_FIN: ndig_q <= nd_d;
			default: ;
		endcase
	end

	assign digits = dig_q;
	assign ndig   = ndig_q;
	assign done   = done_q;

endmodule

`default_nettype wire

>>> rtl/core/ifm_emitter.sv
// ----------------------------------------------------------------------------
// ifm_emitter
// Walks the field segments (left pad, prefix, zeros, digits, right pad)
// and puts out one character beat per cycle, save at segment switches.
// ----------------------------------------------------------------------------
`default_nettype none

module ifm_emitter (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire ifm_pkg::lay_t    lay,
	input  wire ifm_pkg::digits_t digits,
	output logic [7:0]            out_char,
	output logic                  last_char,
	output logic                  char_strobe
);

	localparam logic [2:0] SEG_PADL = 3'd0;
	localparam logic [2:0] SEG_PRE  = 3'd1;
	localparam logic [2:0] SEG_ZERO = 3'd2;
	localparam logic [2:0] SEG_DIG  = 3'd3;
	localparam logic [2:0] SEG_PADR = 3'd4;

	logic          active_q;
	logic [2:0]    seg_q;
	logic [7:0]    cnt_q;
	logic [7:0]    n_q;
	ifm_pkg::lay_t lay_q;
	logic [7:0]    char_q;
	logic          last_q;
	logic          strobe_q;

	logic [4:0] idx_d;
	logic [3:0] dv_d;
	logic [7:0] ch_d;

	// current character
	always_comb begin
		idx_d = cnt_q[4:0] - 5'd1;
		dv_d  = digits[idx_d];
		case (seg_q)
			SEG_PRE:  ch_d = ({6'd0, lay_q.plen} == cnt_q) ? lay_q.pre0 : lay_q.pre1;
			SEG_ZERO: ch_d = "0";
			SEG_DIG: begin
				if (lay_q.single)        ch_d = lay_q.single_char;
				else if (dv_d < 4'd10)   ch_d = 8'd48 + {4'd0, dv_d};
				else if (lay_q.upper)    ch_d = 8'd55 + {4'd0, dv_d};
				else                     ch_d = 8'd87 + {4'd0, dv_d};
			end
			default:  ch_d = " ";
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
			end else if (active_q && cnt_q != 8'd0) begin
				strobe_q <= 1'b1;
				if (n_q + 8'd1 == lay_q.total) begin
					last_q   <= 1'b1;
					active_q <= 1'b0;
				end
			end
		end
	end

	// segment walk
	always_ff @(posedge clk) begin
		if (go) begin
			lay_q <= lay;
			seg_q <= SEG_PADL;
			cnt_q <= lay.padl;
			n_q   <= 8'd0;
		end else if (active_q) begin
			if (cnt_q == 8'd0) begin
				case (seg_q)
					SEG_PADL: begin seg_q <= SEG_PRE;  cnt_q <= {6'd0, lay_q.plen}; end
					SEG_PRE:  begin seg_q <= SEG_ZERO; cnt_q <= lay_q.zeros; end
					SEG_ZERO: begin seg_q <= SEG_DIG;  cnt_q <= {3'd0, lay_q.ndig}; end
					SEG_DIG:  begin seg_q <= SEG_PADR; cnt_q <= lay_q.padr; end
					default:  seg_q <= SEG_PADR;
				endcase
			end else begin
				char_q <= ch_d;
				cnt_q  <= cnt_q - 8'd1;
				n_q    <= n_q + 8'd1;
			end
		end
	end

	assign out_char    = char_q;
	assign last_char   = last_q;
	assign char_strobe = strobe_q;

endmodule

`default_nettype wire
